// File: rtl/crot_pkg.sv
// shared types and constants for the circle/rectangle overlap test
// no dependencies; used by circle_rect_overlap_test, crot_diff and crot_sqr
package crot_pkg;

  localparam int CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_RADIUS   = 2'd2;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

endpackage

// File: rtl/crot_if.sv
// valid/ready channels: rectangle queries in, flag pairs out
// no dependencies
interface crot_rect_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] rect_x_low;
  logic signed [COORD_BITS-1:0] rect_y_low;
  logic signed [COORD_BITS-1:0] rect_x_high;
  logic signed [COORD_BITS-1:0] rect_y_high;

  modport source (output valid, rect_x_low, rect_y_low, rect_x_high, rect_y_high,
                  input ready);
  modport sink   (input valid, rect_x_low, rect_y_low, rect_x_high, rect_y_high,
                  output ready);
endinterface

interface crot_flag_if;
  logic valid;
  logic ready;
  logic contains_rect;
  logic overlaps_rect;

  modport source (output valid, contains_rect, overlaps_rect, input ready);
  modport sink   (input valid, contains_rect, overlaps_rect, output ready);
endinterface

// File: rtl/circle_rect_overlap_test.sv
// circle against axis-aligned rectangle test, top level with config registers
// throughput one rectangle per cycle unless flags_o.ready holds the pipeline,
// through four stages (offsets, classify, square, compare)
// reset clears the stage valid bits and sets centre and radius to zero
// depends on crot_pkg, crot_if, crot_diff and crot_sqr
module circle_rect_overlap_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crot_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]           cfg_wdata_i,
  crot_rect_if.sink                       rect_i,
  crot_flag_if.source                     flags_o
);

  logic signed [COORD_BITS-1:0] center_x_q, center_y_q;
  logic        [COORD_BITS-2:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crot_pkg::CFG_CENTER_X: center_x_q <= $signed(cfg_wdata_i);
        crot_pkg::CFG_CENTER_Y: center_y_q <= $signed(cfg_wdata_i);
        crot_pkg::CFG_RADIUS:   radius_q   <= cfg_wdata_i[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  logic [3:0]     valid_q;
  crot_pkg::adv_t adv;

  assign adv.s4 = !valid_q[3] || flags_o.ready;
  assign adv.s3 = !valid_q[2] || adv.s4;
  assign adv.s2 = !valid_q[1] || adv.s3;
  assign adv.s1 = !valid_q[0] || adv.s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv.s1) valid_q[0] <= rect_i.valid;
      if (adv.s2) valid_q[1] <= valid_q[0];
      if (adv.s3) valid_q[2] <= valid_q[1];
      if (adv.s4) valid_q[3] <= valid_q[2];
    end
  end

  assign rect_i.ready = adv.s1;

  logic [3:0]                 corner_out;
  logic [3:0][COORD_BITS-2:0] corner_mag;
  logic                       far, near;
  logic [1:0][COORD_BITS-1:0] edge_len;

  crot_diff #(
    .COORD_BITS (COORD_BITS)
  ) u_diff (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .center_x_i   (center_x_q),
    .center_y_i   (center_y_q),
    .radius_i     (radius_q),
    .x_low_i      (rect_i.rect_x_low),
    .y_low_i      (rect_i.rect_y_low),
    .x_high_i     (rect_i.rect_x_high),
    .y_high_i     (rect_i.rect_y_high),
    .corner_out_o (corner_out),
    .corner_mag_o (corner_mag),
    .far_o        (far),
    .near_o       (near),
    .edge_o       (edge_len)
  );

  crot_sqr #(
    .COORD_BITS (COORD_BITS)
  ) u_sqr (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .radius_i     (radius_q),
    .corner_out_i (corner_out),
    .corner_mag_i (corner_mag),
    .far_i        (far),
    .near_i       (near),
    .edge_i       (edge_len),
    .contains_o   (flags_o.contains_rect),
    .overlaps_o   (flags_o.overlaps_rect)
  );

  assign flags_o.valid = valid_q[3];

endmodule

// File: rtl/crot_diff.sv
// stages 1 and 2: centre offsets, magnitudes and range classification
// depends on crot_pkg
module crot_diff #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  crot_pkg::adv_t               adv_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [COORD_BITS-2:0] radius_i,
  input  logic signed [COORD_BITS-1:0] x_low_i,
  input  logic signed [COORD_BITS-1:0] y_low_i,
  input  logic signed [COORD_BITS-1:0] x_high_i,
  input  logic signed [COORD_BITS-1:0] y_high_i,
  output logic [3:0]                   corner_out_o,
  output logic [3:0][COORD_BITS-2:0]   corner_mag_o,
  output logic                         far_o,
  output logic                         near_o,
  output logic [1:0][COORD_BITS-1:0]   edge_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int OW = COORD_BITS + 2;
  localparam int CW = COORD_BITS + 3;

  // corner order: x low, x high, y low, y high
  logic signed [3:0][DW-1:0] d_d, d_q;
  logic signed [1:0][OW-1:0] ofs_d, ofs_q;
  logic signed [1:0][DW-1:0] ext_d, ext_q;

  logic [3:0]                 cout_d, cout_q;
  logic [3:0][COORD_BITS-2:0] cmag_d, cmag_q;
  logic                       far_d, far_q, near_d, near_q;
  logic [1:0][COORD_BITS-1:0] edge_d, edge_q;

  logic signed [COORD_BITS-1:0] lo [2];
  logic signed [COORD_BITS-1:0] hi [2];
  logic signed [COORD_BITS-1:0] ctr [2];

  assign lo[0]  = x_low_i;
  assign lo[1]  = y_low_i;
  assign hi[0]  = x_high_i;
  assign hi[1]  = y_high_i;
  assign ctr[0] = center_x_i;
  assign ctr[1] = center_y_i;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      d_d[2*a]   = $signed({lo[a][COORD_BITS-1], lo[a]}) -
                   $signed({ctr[a][COORD_BITS-1], ctr[a]});
      d_d[2*a+1] = $signed({hi[a][COORD_BITS-1], hi[a]}) -
                   $signed({ctr[a][COORD_BITS-1], ctr[a]});
      ofs_d[a]   = $signed({ctr[a][COORD_BITS-1], ctr[a], 1'b0}) -
                   ($signed({{2{lo[a][COORD_BITS-1]}}, lo[a]}) +
                    $signed({{2{hi[a][COORD_BITS-1]}}, hi[a]}));
      ext_d[a]   = $signed({hi[a][COORD_BITS-1], hi[a]}) -
                   $signed({lo[a][COORD_BITS-1], lo[a]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      d_q   <= d_d;
      ofs_q <= ofs_d;
      ext_q <= ext_d;
    end
  end

  logic        [DW-1:0] mag    [4];
  logic        [OW-1:0] omag   [2];
  logic signed [CW-1:0] odist  [2];
  logic signed [CW-1:0] wide   [2];
  logic signed [CW-1:0] diam;
  logic signed [CW-1:0] excess [2];
  logic [1:0]           far_a, near_a;

  always_comb begin
    diam = $signed({3'b000, radius_i, 1'b0});
    for (int i = 0; i < 4; i++) begin
      mag[i]    = d_q[i][DW-1] ? DW'(-d_q[i]) : DW'(d_q[i]);
      cout_d[i] = mag[i] > {2'b00, radius_i};
      cmag_d[i] = mag[i][COORD_BITS-2:0];
    end
    for (int a = 0; a < 2; a++) begin
      omag[a]   = ofs_q[a][OW-1] ? OW'(-ofs_q[a]) : OW'(ofs_q[a]);
      odist[a]  = $signed({1'b0, omag[a]});
      wide[a]   = $signed({{2{ext_q[a][DW-1]}}, ext_q[a]});
      far_a[a]  = odist[a] > (wide[a] + diam);
      near_a[a] = odist[a] <= wide[a];
      excess[a] = odist[a] - wide[a];
      edge_d[a] = excess[a][COORD_BITS-1:0];
    end
    far_d  = |far_a;
    near_d = |near_a;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      cout_q <= cout_d;
      cmag_q <= cmag_d;
      far_q  <= far_d;
      near_q <= near_d;
      edge_q <= edge_d;
    end
  end

  assign corner_out_o = cout_q;
  assign corner_mag_o = cmag_q;
  assign far_o        = far_q;
  assign near_o       = near_q;
  assign edge_o       = edge_q;

endmodule

// File: rtl/crot_sqr.sv
// stages 3 and 4: squares, then sum and compare against the squared radius
// depends on crot_pkg
module crot_sqr #(
  parameter int COORD_BITS = 16
) (
  input  logic                       clk_i,
  input  crot_pkg::adv_t             adv_i,
  input  logic [COORD_BITS-2:0]      radius_i,
  input  logic [3:0]                 corner_out_i,
  input  logic [3:0][COORD_BITS-2:0] corner_mag_i,
  input  logic                       far_i,
  input  logic                       near_i,
  input  logic [1:0][COORD_BITS-1:0] edge_i,
  output logic                       contains_o,
  output logic                       overlaps_o
);

  localparam int SQ = 2 * COORD_BITS - 2;
  localparam int EQ = 2 * COORD_BITS;

  logic [SQ-1:0]        rsq_q;
  logic [3:0][SQ-1:0]   csq_d, csq_q;
  logic [1:0][EQ-1:0]   esq_d, esq_q;
  logic [3:0]           cout_q;
  logic                 far_q, near_q;

  // radius must only change while idle (the block does not enforce this), so the registered square is current
  always_ff @(posedge clk_i) begin
    rsq_q <= radius_i * radius_i;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      csq_d[i] = corner_mag_i[i] * corner_mag_i[i];
    end
    for (int a = 0; a < 2; a++) begin
      esq_d[a] = edge_i[a] * edge_i[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      csq_q  <= csq_d;
      esq_q  <= esq_d;
      cout_q <= corner_out_i;
      far_q  <= far_i;
      near_q <= near_i;
    end
  end

  logic [SQ:0]   csum [4];
  logic [3:0]    cin;
  logic [EQ:0]   esum;
  logic          contains_d, overlaps_d;
  logic          contains_q, overlaps_q;

  always_comb begin
    for (int xi = 0; xi < 2; xi++) begin
      for (int yi = 0; yi < 2; yi++) begin
        csum[2*yi+xi] = {1'b0, csq_q[xi]} + {1'b0, csq_q[2+yi]};
        cin[2*yi+xi]  = !cout_q[xi] && !cout_q[2+yi] &&
                        (csum[2*yi+xi] <= {1'b0, rsq_q});
      end
    end
    contains_d = &cin;
    esum       = {1'b0, esq_q[0]} + {1'b0, esq_q[1]};
    priority if (far_q) begin
      overlaps_d = 1'b0;
    end else if (near_q) begin
      overlaps_d = 1'b1;
    end else begin
      overlaps_d = esum <= {1'b0, rsq_q, 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      contains_q <= contains_d;
      overlaps_q <= overlaps_d;
    end
  end

  assign contains_o = contains_q;
  assign overlaps_o = overlaps_q;

endmodule
